// File: src/dsa_pkg.sv
// Package for the deduplicating slot allocator: status codes and beat structs.
// No dependencies.
package dsa_pkg;

  localparam int unsigned HandleW = 10;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned CapW    = 11;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_REUSED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_INVALID  = 3'd4
  } status_e;

  typedef enum logic {
    REQ_CREATE  = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [0:0]         req_type;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] release_index;
  } req_t;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [2:0]         status;
    logic               write_enable;
    logic               write_empty;
    logic [KeyW-1:0]    written_key;
  } rsp_t;

endpackage

// File: src/dsa_table.sv
// Slot table memory: one entry holds the key of a slot.
// Synchronous write, registered read. Uses dsa_pkg.
module dsa_table import dsa_pkg::*; #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned KeyWidth = 64
) (
  input  logic                     clk_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [KeyWidth-1:0]      rd_key_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [KeyWidth-1:0]      wr_key_i
);

  logic [KeyWidth-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_key_i;
    end
    rd_key_o <= mem[rd_addr_i];
  end

endmodule

// File: src/dsa_used.sv
// Used-bit memory with a clearing pass after reset, one entry a cycle.
// Registered read. Uses dsa_pkg.
module dsa_used import dsa_pkg::*; #(
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  output logic                     init_done_o,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic                     rd_used_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic                     wr_used_i
);

  localparam int unsigned AW = $clog2(Depth);

  logic mem [Depth];
  logic [AW:0] clr_q, clr_d;

  assign init_done_o = clr_q[AW];
  assign clr_d = init_done_o ? clr_q
               : ((clr_q[AW-1:0] == AW'(Depth-1)) ? {1'b1, AW'(0)} : clr_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!init_done_o) begin
      mem[clr_q[AW-1:0]] <= 1'b0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_used_i;
    end
    rd_used_o <= mem[rd_addr_i];
  end

endmodule

// File: src/dedup_slot_allocator.sv
// Top level of the deduplicating slot allocator: sequencer that walks the
// slot table. Instantiates dsa_table and dsa_used; uses dsa_pkg.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------
//  request | start_i, busy_o            | req_i   (req_t)
//  result  | done_o (one-cycle strobe)  | rsp_o   (rsp_t)
//  config  | cfg_valid_i, cfg_ready_o   | cfg_data_i (capacity)
//
// Sequencing: a release keeps busy_o high in S_REL and S_DONE, the latter carrying
// the result strobe. A create walks the table twice, one slot a cycle through
// the registered read port: first a match scan over all slots below capacity,
// then a free scan from the hint. After reset a clearing pass over the used bits
// runs with busy_o high. The result strobe cannot be stalled; the block goes
// idle in the cycle after it.
module dedup_slot_allocator import dsa_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 1024,
  parameter int unsigned KEY_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [CapW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MATCH = 5'b00010,
    S_FREE  = 5'b00100,
    S_REL   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CapW-1:0] cap_reg_q;
  logic [CW-1:0]   cap;
  logic [CW-1:0]   hint_q, hint_d;
  // address of the slot being issued and the one whose data returns now
  logic [CW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   chk_q, chk_d;
  logic            chk_v_q, chk_v_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [HandleW-1:0] rel_q, rel_d;
  rsp_t            rsp_q, rsp_d;
  logic            done_q, done_d;
  logic            init_done;
  logic            rd_used;
  logic [KEY_WIDTH-1:0] rd_key;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            wr_used;
  logic [KEY_WIDTH-1:0] wr_key;
  logic [AW-1:0]   rd_addr;

  // clamp capacity to the table size
  assign cap = (cap_reg_q > CapW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cap_reg_q);

  assign busy_o      = (state_q != S_IDLE) || !init_done;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign rd_addr     = ptr_q[AW-1:0];

  dsa_table #(.Depth(MAX_SLOTS), .KeyWidth(KEY_WIDTH)) u_table (
    .clk_i, .rd_addr_i(rd_addr), .rd_key_o(rd_key),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_key_i(wr_key)
  );

  dsa_used #(.Depth(MAX_SLOTS)) u_used (
    .clk_i, .rst_ni, .init_done_o(init_done), .rd_addr_i(rd_addr),
    .rd_used_o(rd_used), .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_used_i(wr_used)
  );

  always_comb begin
    state_d = state_q;
    hint_d  = hint_q;
    ptr_d   = ptr_q;
    chk_d   = ptr_q;
    chk_v_d = 1'b0;
    key_d   = key_q;
    rel_d   = rel_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    wr_en   = 1'b0;
    wr_addr = chk_q[AW-1:0];
    wr_used = 1'b1;
    wr_key  = key_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && init_done) begin
          key_d = req_i.key[KEY_WIDTH-1:0];
          rel_d = req_i.release_index;
          if (req_i.req_type == REQ_RELEASE) begin
            state_d = S_REL;
          end else begin
            ptr_d   = '0;
            chk_v_d = 1'b0;
            state_d = S_MATCH;
          end
        end
      end
      S_REL: begin
        // compare the full index so that slots past a narrow table stay invalid
        rsp_d = '{handle: rel_q, status: ST_INVALID, write_enable: 1'b0,
                  write_empty: 1'b0, written_key: '0};
        if (CapW'(rel_q) < CapW'(cap)) begin
          rsp_d.status       = ST_RELEASED;
          rsp_d.write_enable = 1'b1;
          rsp_d.write_empty  = 1'b1;
          wr_en   = 1'b1;
          wr_addr = rel_q[AW-1:0];
          wr_used = 1'b0;
          wr_key  = '0;
          if (CW'(rel_q) < hint_q) begin
            hint_d = CW'(rel_q);
          end
        end
        done_d  = 1'b1;
        state_d = S_DONE;
      end
      S_MATCH: begin
        // issue next read while checking the data of the previous one
        if (chk_v_q && rd_used && rd_key == key_q) begin
          rsp_d = '{handle: HandleW'(chk_q), status: ST_REUSED, write_enable: 1'b0,
                    write_empty: 1'b0, written_key: '0};
          done_d  = 1'b1;
          state_d = S_DONE;
        end else if (ptr_q >= cap) begin
          if (!chk_v_q) begin
            // drain the last check first, then start the free scan
            ptr_d   = hint_q;
            state_d = S_FREE;
          end else begin
            chk_v_d = 1'b0;
          end
        end else begin
          ptr_d   = ptr_q + 1'b1;
          chk_v_d = 1'b1;
        end
      end
      S_FREE: begin
        if (chk_v_q && !rd_used) begin
          rsp_d = '{handle: HandleW'(chk_q), status: ST_NEW, write_enable: 1'b1,
                    write_empty: 1'b0, written_key: KeyW'(key_q)};
          wr_en   = 1'b1;
          wr_addr = chk_q[AW-1:0];
          hint_d  = chk_q + 1'b1;
          done_d  = 1'b1;
          state_d = S_DONE;
        end else if (ptr_q >= cap) begin
          if (!chk_v_q) begin
            rsp_d = '{handle: '0, status: ST_FULL, write_enable: 1'b0,
                      write_empty: 1'b0, written_key: '0};
            done_d  = 1'b1;
            state_d = S_DONE;
          end
        end else begin
          ptr_d   = ptr_q + 1'b1;
          chk_v_d = 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cap_reg_q <= CapW'(MAX_SLOTS);
      hint_q    <= '0;
      ptr_q     <= '0;
      chk_q     <= '0;
      chk_v_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      ptr_q   <= ptr_d;
      chk_q   <= chk_d;
      chk_v_q <= chk_v_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_reg_q <= cfg_data_i;
      end
    end
  end

  // payload registers: request beat fields and the result beat
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rel_q <= rel_d;
    rsp_q <= rsp_d;
  end

endmodule
